FILE: sv/gbf_pkg.sv
// ----------------------------------------------------------------------------
// gbf_pkg
// shared types and constants of the binary log framer
// ----------------------------------------------------------------------------
package gbf_pkg;

   // sync pattern of a binary log header
   localparam logic [7:0] SYNC_A = 8'hAA;
   localparam logic [7:0] SYNC_B = 8'h44;
   localparam logic [7:0] SYNC_C = 8'h12;

   // slack added to header length plus message length
   localparam logic [16:0] LEN_SLACK = 17'd3;

   // field widths
   localparam int unsigned POS_W   = 15;
   localparam int unsigned STORE_W = 14;
   localparam int unsigned ABORT_W = 14;
   localparam int unsigned ID_W    = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // header phases with their own action
   localparam int unsigned PH_SYNC_A = 0;
   localparam int unsigned PH_SYNC_B = 1;
   localparam int unsigned PH_SYNC_C = 2;
   localparam int unsigned PH_HDR    = 3;
   localparam int unsigned PH_ID_LO  = 4;
   localparam int unsigned PH_ID_HI  = 5;
   localparam int unsigned PH_SKIP_A = 6;
   localparam int unsigned PH_SKIP_B = 7;
   localparam int unsigned PH_LEN_LO = 8;
   localparam int unsigned PH_LEN_HI = 9;
   localparam int unsigned PH_SKIP_C = 10;

   // reset values of the registers
   localparam logic [ABORT_W-1:0] ABORT_LIMIT_RST = 14'd10000;
   localparam logic [ID_W-1:0]    POSITION_ID_RST = 16'h00F1;
   localparam logic [ID_W-1:0]    RANGE_ID_RST    = 16'h002B;
   localparam logic [ID_W-1:0]    SATELLITE_ID_RST = 16'h05AB;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ABORT_LIMIT  = 2'd0,
      CSR_POSITION_ID  = 2'd1,
      CSR_RANGE_ID     = 2'd2,
      CSR_SATELLITE_ID = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_OTHER     = 2'd0,
      KIND_POSITION  = 2'd1,
      KIND_RANGE     = 2'd2,
      KIND_SATELLITE = 2'd3
   } frame_kind_type;

   typedef struct packed {
      logic [ABORT_W-1:0] abort_limit;
      logic [ID_W-1:0]    position_log_id;
      logic [ID_W-1:0]    range_log_id;
      logic [ID_W-1:0]    satellite_log_id;
   } cfg_type;

   typedef struct packed {
      logic [7:0]         stored_byte;
      logic [STORE_W-1:0] store_position;
      logic               frame_done;
      frame_kind_type     frame_kind;
      logic [ID_W-1:0]    message_id;
      logic [7:0]         header_length;
      logic [15:0]        message_length;
   } result_type;

endpackage

FILE: sv/gbf_if.sv
// ----------------------------------------------------------------------------
// gbf channel interfaces
// byte input, framed result and register write channels
// ----------------------------------------------------------------------------
interface gbf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gbf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  stored_byte;
   logic [13:0] store_position;
   logic        frame_done;
   logic [1:0]  frame_kind;
   logic [15:0] message_id;
   logic [7:0]  header_length;
   logic [15:0] message_length;

   modport source (output valid, output stored_byte, output store_position,
                   output frame_done, output frame_kind, output message_id,
                   output header_length, output message_length, input ready);
   modport sink   (input valid, input stored_byte, input store_position,
                   input frame_done, input frame_kind, input message_id,
                   input header_length, input message_length, output ready);
endinterface

interface gbf_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/gbf_csr.sv
// ----------------------------------------------------------------------------
// gbf_csr
// configuration registers of the framer, written one beat at a time
// ----------------------------------------------------------------------------
module gbf_csr (
   input  logic              clock,
   input  logic              reset,
   gbf_csr_if.sink           csr_if,
   output gbf_pkg::cfg_type  cfg
);

   gbf_pkg::cfg_type cfg_ff;
   gbf_pkg::cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (gbf_pkg::csr_index_type'(csr_if.index))
            gbf_pkg::CSR_ABORT_LIMIT: begin
               cfg_in.abort_limit = csr_if.data[gbf_pkg::ABORT_W-1:0];
            end
            gbf_pkg::CSR_POSITION_ID: begin
               cfg_in.position_log_id = csr_if.data;
            end
            gbf_pkg::CSR_RANGE_ID: begin
               cfg_in.range_log_id = csr_if.data;
            end
            gbf_pkg::CSR_SATELLITE_ID: begin
               cfg_in.satellite_log_id = csr_if.data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.abort_limit      <= gbf_pkg::ABORT_LIMIT_RST;
         cfg_ff.position_log_id  <= gbf_pkg::POSITION_ID_RST;
         cfg_ff.range_log_id     <= gbf_pkg::RANGE_ID_RST;
         cfg_ff.satellite_log_id <= gbf_pkg::SATELLITE_ID_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/gbf_framer.sv
// ----------------------------------------------------------------------------
// gbf_framer
// framing state and the per-byte update: sync hunt, header capture, end check
// ----------------------------------------------------------------------------
module gbf_framer #(
   parameter int unsigned PHASE_BITS = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          rx_byte,
   input  gbf_pkg::cfg_type    cfg,
   output gbf_pkg::result_type result
);

   localparam int unsigned CMP_W =
      (PHASE_BITS > gbf_pkg::ABORT_W) ? PHASE_BITS : gbf_pkg::ABORT_W;

   localparam logic [PHASE_BITS-1:0] PH_SYNC_A = PHASE_BITS'(gbf_pkg::PH_SYNC_A);
   localparam logic [PHASE_BITS-1:0] PH_SYNC_B = PHASE_BITS'(gbf_pkg::PH_SYNC_B);
   localparam logic [PHASE_BITS-1:0] PH_SYNC_C = PHASE_BITS'(gbf_pkg::PH_SYNC_C);
   localparam logic [PHASE_BITS-1:0] PH_HDR    = PHASE_BITS'(gbf_pkg::PH_HDR);
   localparam logic [PHASE_BITS-1:0] PH_ID_LO  = PHASE_BITS'(gbf_pkg::PH_ID_LO);
   localparam logic [PHASE_BITS-1:0] PH_ID_HI  = PHASE_BITS'(gbf_pkg::PH_ID_HI);
   localparam logic [PHASE_BITS-1:0] PH_SKIP_A = PHASE_BITS'(gbf_pkg::PH_SKIP_A);
   localparam logic [PHASE_BITS-1:0] PH_SKIP_B = PHASE_BITS'(gbf_pkg::PH_SKIP_B);
   localparam logic [PHASE_BITS-1:0] PH_LEN_LO = PHASE_BITS'(gbf_pkg::PH_LEN_LO);
   localparam logic [PHASE_BITS-1:0] PH_LEN_HI = PHASE_BITS'(gbf_pkg::PH_LEN_HI);
   localparam logic [PHASE_BITS-1:0] PH_SKIP_C = PHASE_BITS'(gbf_pkg::PH_SKIP_C);

   logic [PHASE_BITS-1:0]        phase_ff, phase_in;
   logic [gbf_pkg::POS_W-1:0]    position_count_ff, position_count_in;
   logic [7:0]                   header_len_ff, header_len_in;
   logic [gbf_pkg::ID_W-1:0]     msg_id_ff, msg_id_in;
   logic [15:0]                  msg_len_ff, msg_len_in;

   logic [PHASE_BITS-1:0]        phase_step;
   logic [gbf_pkg::POS_W-1:0]    pos_step;
   logic [16:0]                  frame_end;
   logic                         frame_done;
   gbf_pkg::frame_kind_type      frame_kind;

   always_comb begin
      phase_step    = phase_ff + 1'b1;
      pos_step      = position_count_ff + 1'b1;
      header_len_in = header_len_ff;
      msg_id_in     = msg_id_ff;
      msg_len_in    = msg_len_ff;
      phase_in      = phase_step;
      position_count_in = pos_step;

      case (phase_ff)
         PH_SYNC_A: begin
            if (rx_byte != gbf_pkg::SYNC_A) begin
               phase_in          = '0;
               position_count_in = '0;
            end
         end
         PH_SYNC_B: begin
            if (rx_byte != gbf_pkg::SYNC_B) begin
               phase_in          = '0;
               position_count_in = '0;
            end
         end
         PH_SYNC_C: begin
            if (rx_byte != gbf_pkg::SYNC_C) begin
               phase_in          = '0;
               position_count_in = '0;
            end
         end
         PH_HDR:    header_len_in = rx_byte;
         PH_ID_LO:  msg_id_in     = {8'h00, rx_byte};
         PH_ID_HI:  msg_id_in     = {rx_byte, msg_id_ff[7:0]};
         PH_LEN_LO: msg_len_in    = {8'h00, rx_byte};
         PH_LEN_HI: msg_len_in    = {rx_byte, msg_len_ff[7:0]};
         PH_SKIP_A, PH_SKIP_B, PH_SKIP_C: begin
            phase_in = phase_step;
         end
         default: begin
            // runaway frame
            if (CMP_W'(phase_ff) == CMP_W'(cfg.abort_limit)) begin
               phase_in          = '0;
               position_count_in = '0;
            end
         end
      endcase

      frame_end  = 17'(header_len_in) + 17'(msg_len_in) + gbf_pkg::LEN_SLACK;
      frame_done = (phase_in > PH_SKIP_C) && (17'(position_count_in) > frame_end);

      // first match wins
      if (msg_id_in == cfg.position_log_id) begin
         frame_kind = gbf_pkg::KIND_POSITION;
      end else if (msg_id_in == cfg.range_log_id) begin
         frame_kind = gbf_pkg::KIND_RANGE;
      end else if (msg_id_in == cfg.satellite_log_id) begin
         frame_kind = gbf_pkg::KIND_SATELLITE;
      end else begin
         frame_kind = gbf_pkg::KIND_OTHER;
      end

      if (frame_done) begin
         phase_in          = '0;
         position_count_in = '0;
      end else begin
         frame_kind = gbf_pkg::KIND_OTHER;
      end

      result.stored_byte    = rx_byte;
      result.store_position = position_count_ff[gbf_pkg::STORE_W-1:0];
      result.frame_done     = frame_done;
      result.frame_kind     = frame_kind;
      result.message_id     = msg_id_in;
      result.header_length  = header_len_in;
      result.message_length = msg_len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= '0;
         position_count_ff <= '0;
         header_len_ff     <= '0;
         msg_id_ff         <= '0;
         msg_len_ff        <= '0;
      end else if (advance) begin
         phase_ff          <= phase_in;
         position_count_ff <= position_count_in;
         header_len_ff     <= header_len_in;
         msg_id_ff         <= msg_id_in;
         msg_len_ff        <= msg_len_in;
      end
   end

`ifndef SYNTHESIS
   a_done_rehunts: assert property (@(posedge clock) disable iff (reset)
      advance && result.frame_done |=> phase_ff == '0 && position_count_ff == '0)
      else $error("framer did not rehunt after a completed frame");

   a_header_capture: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_HDR |=> header_len_ff == $past(rx_byte))
      else $error("header length byte not captured");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(position_count_ff))
      else $error("framing state moved without a byte");
`endif

endmodule

FILE: sv/gnss_binary_log_framer_core.sv
// ----------------------------------------------------------------------------
// gnss_binary_log_framer_core
// frames binary gnss logs from a received byte stream
// ----------------------------------------------------------------------------
// usage
//  - req_if carries one received byte per beat; rsp_if returns one result beat
//    per byte: the byte, its frame store position, the captured header fields
//    and, on the byte that closes a frame, frame_done with the id class
//  - csr_if writes abort_limit (0) and the three log ids (1..3); it is always
//    ready and is meant to be written while no byte is in flight
//  - a byte taken from req_if is held in the input stage register, then moves
//    through the framing update into the result register that drives rsp_if
//  - throughput: one byte per cycle unless rsp_if stalls; the whole framing
//    update sits between the input stage register and the result register
//  - a stalled rsp_if holds its beat; the input stage keeps taking a byte as
//    long as it is empty or the result register can move on, so one extra
//    byte is buffered while the receiver stalls
//  - reset clears both stages, the framing state and the captured fields, and
//    loads the default register values; the framer starts hunting for sync
// ----------------------------------------------------------------------------
module gnss_binary_log_framer_core #(
   parameter int unsigned PHASE_BITS = 14
) (
   input  logic      clock,
   input  logic      reset,
   gbf_req_if.sink   req_if,
   gbf_rsp_if.source rsp_if,
   gbf_csr_if.sink   csr_if
);

   // configuration
   gbf_pkg::cfg_type    cfg;

   // input stage
   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_byte_ff, s1_byte_in;

   // result stage
   logic                rsp_valid_ff, rsp_valid_in;
   gbf_pkg::result_type rsp_ff, rsp_in;
   gbf_pkg::result_type result;

   logic                rsp_free;
   logic                advance;
   logic                req_beat;

   gbf_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   gbf_framer #(
      .PHASE_BITS (PHASE_BITS)
   ) u_framer (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (s1_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // handshake: result register moves on when empty or taken
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign advance      = s1_valid_ff && rsp_free;
   assign req_if.ready = !s1_valid_ff || rsp_free;
   assign req_beat     = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_beat) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_if.rx_byte;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      rsp_ff     <= rsp_in;
   end

   // result channel
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.stored_byte    = rsp_ff.stored_byte;
   assign rsp_if.store_position = rsp_ff.store_position;
   assign rsp_if.frame_done     = rsp_ff.frame_done;
   assign rsp_if.frame_kind     = rsp_ff.frame_kind;
   assign rsp_if.message_id     = rsp_ff.message_id;
   assign rsp_if.header_length  = rsp_ff.header_length;
   assign rsp_if.message_length = rsp_ff.message_length;

`ifndef SYNTHESIS
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("input stage lost a waiting byte");

   a_byte_echo: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && rsp_ff.stored_byte == $past(s1_byte_ff))
      else $error("result beat does not echo its byte");

   a_kind_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.frame_done |-> rsp_ff.frame_kind == gbf_pkg::KIND_OTHER)
      else $error("frame kind set without a completed frame");
`endif

endmodule
